// ===== rtl/gnt_pkg.sv =====
// ----------------------------------------------------------------------------
// gnt_pkg: shared types and constants for the gradient noise block
// table sizes, request codes and the queue entry passed from front to back
// ----------------------------------------------------------------------------
package gnt_pkg;

  localparam int unsigned TableSize  = 256;
  localparam int unsigned IdxW       = $clog2(TableSize);
  localparam int unsigned MaxOctaves = 8;
  localparam int unsigned OctW       = $clog2(MaxOctaves);

  localparam logic signed [18:0] OutMax = 19'sd262143;
  localparam logic signed [18:0] OutMin = -19'sd262144;

  typedef enum logic [1:0] {
    REQ_NOISE = 2'd0,
    REQ_TURB  = 2'd1,
    REQ_PERM  = 2'd2,
    REQ_GRAD  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_NONE = 2'd3
  } sel_e;

  // evaluator states
  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SMOOTH, ST_CORNER, ST_DRAIN, ST_FOLD, ST_OUT
  } st_e;

  // evaluation job handed from front to back
  typedef struct packed {
    logic              turb;
    logic [OctW:0]     n_oct;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

  // table write request
  typedef struct packed {
    logic              perm_we;
    sel_e              sel;
    logic              grad_we;
    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   pval;
    logic [47:0]       grad;
  } twr_t;

endpackage

// ===== rtl/gnt_front.sv =====
// ----------------------------------------------------------------------------
// gnt_front: request decoder
// loads go to the table write port once nothing is pending, evaluations are
// queued
// ----------------------------------------------------------------------------
module gnt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [1:0]        table_select_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        perm_value_i,
  input  logic [47:0]       grad_i,
  input  logic [95:0]       point_i,
  input  logic [3:0]        octave_count_i,
  output gnt_pkg::twr_t     twr_o,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output gnt_pkg::job_t     q_job_o
);
  import gnt_pkg::*;

  localparam int unsigned QDepth = 2;

  job_t       q_mem [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       acc, push, pop, is_eval;
  job_t       job;
  req_e       req;

  assign req      = req_e'(req_type_i);
  assign is_eval  = (req == REQ_NOISE) || (req == REQ_TURB);
  // a load waits until every earlier evaluation has finished reading the tables
  assign s_ready_o = is_eval ? (cnt_q != 2'(QDepth)) : ((cnt_q == 2'd0) && q_ready_i);
  assign acc      = s_valid_i && s_ready_o;
  assign push     = acc && is_eval;
  assign pop      = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_job_o  = q_mem[rp_q];

  always_comb begin
    job.turb = (req == REQ_TURB);
    if (octave_count_i > 4'(MaxOctaves)) begin
      job.n_oct = (OctW+1)'(MaxOctaves);
    end else begin
      job.n_oct = octave_count_i[OctW:0];
    end
    job.px = point_i[31:0];
    job.py = point_i[63:32];
    job.pz = point_i[95:64];
  end

  always_comb begin
    twr_o.perm_we = acc && (req == REQ_PERM);
    twr_o.sel     = sel_e'(table_select_i);
    twr_o.grad_we = acc && (req == REQ_GRAD);
    twr_o.idx     = entry_index_i[IdxW-1:0];
    twr_o.pval    = perm_value_i[IdxW-1:0];
    twr_o.grad    = grad_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/gnt_back.sv =====
// ----------------------------------------------------------------------------
// gnt_back: noise evaluator
// per octave: a setup step, a smoothstep step, then eight corners through a pipeline
// reading the permutation and gradient memories, a drain of that pipeline, then
// the octave sum is folded in
module gnt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gnt_pkg::twr_t     twr_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  gnt_pkg::job_t     q_job_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [18:0]       m_data_o
);
  import gnt_pkg::*;

  logic [IdxW-1:0] perm_x [TableSize];
  logic [IdxW-1:0] perm_y [TableSize];
  logic [IdxW-1:0] perm_z [TableSize];
  logic [47:0]     grad_m [TableSize];

  always_ff @(posedge clk_i) begin
    if (twr_i.perm_we && twr_i.sel == SEL_X) perm_x[twr_i.idx] <= twr_i.pval;
    if (twr_i.perm_we && twr_i.sel == SEL_Y) perm_y[twr_i.idx] <= twr_i.pval;
    if (twr_i.perm_we && twr_i.sel == SEL_Z) perm_z[twr_i.idx] <= twr_i.pval;
    if (twr_i.grad_we) grad_m[twr_i.idx] <= twr_i.grad;
  end

  st_e           st_q, st_d;
  logic          turb_q;
  logic [OctW:0] n_q, k_q;
  logic [31:0]   x_q, y_q, z_q;
  logic [15:0]   f_q [3];
  logic [16:0]   s_q [3];
  logic [31:0]   t2_q [3];
  logic [2:0]    cn_q;     // corner issue counter
  logic [3:0]    drn_q;    // pipeline drain counter
  logic signed [68:0] osum_q;
  logic signed [68:0] acc_q;
  logic [18:0]   res_q;

  // smoothstep: t*t is registered first, then multiplied by (3-2t)
  logic [31:0] tt [3];
  logic [16:0] sm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tt[i] = 32'(f_q[i]) * 32'(f_q[i]);
      sm[i] = 17'((49'(t2_q[i][31:16]) * (49'(3*65536) - 49'({f_q[i], 1'b0}))) >> 16);
    end
  end

  // corner pipeline stage 1: perm reads
  logic       v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [2:0] c1_q, c2_q;
  logic [IdxW-1:0] cx, cy, cz;
  logic [IdxW-1:0] pxr_q, pyr_q, pzr_q;
  assign cx = x_q[16 +: IdxW] + IdxW'(cn_q[2]);
  assign cy = y_q[16 +: IdxW] + IdxW'(cn_q[1]);
  assign cz = z_q[16 +: IdxW] + IdxW'(cn_q[0]);
  logic issue;
  assign issue = (st_q == ST_CORNER);

  always_ff @(posedge clk_i) begin
    pxr_q <= perm_x[cx];
    pyr_q <= perm_y[cy];
    pzr_q <= perm_z[cz];
  end

  // stage 2: gradient read
  logic [47:0] g_q;
  always_ff @(posedge clk_i) begin
    g_q <= grad_m[pxr_q ^ pyr_q ^ pzr_q];
  end

  // stage 3: component products and weight product wx*wy
  logic signed [16:0] ox, oy, oz;
  logic [16:0] wx, wy, wz;
  logic signed [33:0] dx_q, dy_q, dz_q;
  logic [32:0] wxy_q;
  logic [16:0] wz3_q;
  always_comb begin
    ox = c2_q[2] ? $signed({1'b0, f_q[0]}) - 17'sd65536 : $signed({1'b0, f_q[0]});
    oy = c2_q[1] ? $signed({1'b0, f_q[1]}) - 17'sd65536 : $signed({1'b0, f_q[1]});
    oz = c2_q[0] ? $signed({1'b0, f_q[2]}) - 17'sd65536 : $signed({1'b0, f_q[2]});
    wx = c2_q[2] ? s_q[0] : 17'd65536 - s_q[0];
    wy = c2_q[1] ? s_q[1] : 17'd65536 - s_q[1];
    wz = c2_q[0] ? s_q[2] : 17'd65536 - s_q[2];
  end
  always_ff @(posedge clk_i) begin
    dx_q  <= 34'($signed(g_q[15:0]) * ox);
    dy_q  <= 34'($signed(g_q[31:16]) * oy);
    dz_q  <= 34'($signed(g_q[47:32]) * oz);
    wxy_q <= 33'(wx) * 33'(wy);
    wz3_q <= wz;
  end

  // stage 4: dot sum and full weight
  logic signed [35:0] dot_q;
  logic [32:0] w_q;
  always_ff @(posedge clk_i) begin
    dot_q <= 36'(dx_q) + 36'(dy_q) + 36'(dz_q);
    w_q   <= 33'(({1'b0, wxy_q[32:16]} * 34'(wz3_q)) >> 16);
  end

  // stage 5: corner term
  logic signed [53:0] term_q;
  always_ff @(posedge clk_i) begin
    term_q <= 54'(dot_q * $signed({1'b0, w_q[17:0]}));
  end

  logic signed [68:0] shifted;
  assign shifted = osum_q >>> k_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (q_valid_i) st_d = (q_job_i.turb && q_job_i.n_oct == '0) ? ST_OUT
                                       : ST_SETUP;
      ST_SETUP:  st_d = ST_SMOOTH;
      ST_SMOOTH: st_d = ST_CORNER;
      ST_CORNER: if (cn_q == 3'd7) st_d = ST_DRAIN;
      ST_DRAIN:  if (drn_q == 4'd6) st_d = ST_FOLD;
      ST_FOLD:   st_d = (turb_q && (k_q + 1'b1) < n_q) ? ST_SETUP : ST_OUT;
      ST_OUT:    if (m_ready_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  assign q_ready_o = (st_q == ST_IDLE);
  assign m_valid_o = (st_q == ST_OUT);
  assign m_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    v1_q <= issue; c1_q <= cn_q;
    v2_q <= v1_q;  c2_q <= c1_q;
    v3_q <= v2_q;
    v4_q <= v3_q;
    v5_q <= v4_q;
    if (st_q == ST_IDLE && q_valid_i) begin
      turb_q <= q_job_i.turb;
      n_q    <= q_job_i.n_oct;
      x_q    <= q_job_i.px;
      y_q    <= q_job_i.py;
      z_q    <= q_job_i.pz;
      k_q    <= '0;
      acc_q  <= '0;
      res_q  <= '0;
    end
    if (st_q == ST_SETUP) begin
      f_q[0] <= x_q[15:0];
      f_q[1] <= y_q[15:0];
      f_q[2] <= z_q[15:0];
      osum_q <= '0;
    end
    if (st_q == ST_SMOOTH) begin
      for (int i = 0; i < 3; i++) t2_q[i] <= tt[i];
    end
    if (st_q == ST_CORNER && cn_q == 3'd0) begin
      for (int i = 0; i < 3; i++) s_q[i] <= sm[i];
    end
    if (v5_q) osum_q <= osum_q + 69'(term_q);
    if (st_q == ST_FOLD) begin
      acc_q <= acc_q + shifted;
      k_q   <= k_q + 1'b1;
      x_q   <= {x_q[30:0], 1'b0};
      y_q   <= {y_q[30:0], 1'b0};
      z_q   <= {z_q[30:0], 1'b0};
    end
    if (st_q == ST_FOLD && !turb_q) begin
      if ((osum_q >>> 31) > 69'(OutMax))      res_q <= OutMax;
      else if ((osum_q >>> 31) < 69'(OutMin)) res_q <= OutMin;
      else res_q <= 19'(osum_q >>> 31);
    end
    if (st_q == ST_FOLD && turb_q && st_d == ST_OUT) begin
      if (((acc_q + shifted) >>> 31) < 0) begin
        if (-((acc_q + shifted) >>> 31) > 69'(OutMax)) res_q <= OutMax;
        else res_q <= 19'(-((acc_q + shifted) >>> 31));
      end else begin
        if (((acc_q + shifted) >>> 31) > 69'(OutMax)) res_q <= OutMax;
        else res_q <= 19'((acc_q + shifted) >>> 31);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cn_q  <= 3'd0;
      drn_q <= 4'd0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CORNER) cn_q <= cn_q + 3'd1;
      else cn_q <= 3'd0;
      if (st_q == ST_DRAIN) drn_q <= drn_q + 4'd1;
      else drn_q <= 4'd0;
    end
  end

endmodule

// ===== rtl/gradient_noise_turbulence.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_turbulence: 3d gradient noise and turbulence over loaded tables
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata request word, tuser req_type
//   m_axis    out  tvalid/tready        tdata noise_value
//   cfg       in   cfg_valid/cfg_ready  octave_count
//
// each octave steps through setup, smoothstep, eight corner issues and a drain
// of the table read pipeline, then the fold.
// reset clears control only; tables are undefined until loaded.
// a two-entry queue lets the front take evaluation words while the evaluator
// is busy; a load word stalls until the queue and the evaluator are empty.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // table_select, entry_index, perm_value, grad_x, grad_y, grad_z,
  // point_x, point_y, point_z (bits 0..161), zero filled
  input  logic [167:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // noise_value, zero filled
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_data_i
);
  import gnt_pkg::*;

  logic [3:0] oct_q;
  twr_t       twr;
  logic       qv, qr;
  job_t       qj;
  logic [18:0] res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) oct_q <= 4'd7;
    else if (cfg_valid_i) oct_q <= cfg_data_i;
  end

  gnt_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .table_select_i (s_axis_tdata[1:0]),
    .entry_index_i  (s_axis_tdata[9:2]),
    .perm_value_i   (s_axis_tdata[17:10]),
    .grad_i         (s_axis_tdata[65:18]),
    .point_i        (s_axis_tdata[161:66]),
    .octave_count_i (oct_q),
    .twr_o          (twr),
    .q_valid_o      (qv),
    .q_ready_i      (qr),
    .q_job_o        (qj)
  );

  gnt_back u_back (
    .clk_i, .rst_ni,
    .twr_i     (twr),
    .q_valid_i (qv),
    .q_ready_o (qr),
    .q_job_i   (qj),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule
